// ===== sv/chg_pkg.sv =====
package chg_pkg;

  localparam int NUM_DENOMS     = 7;
  localparam int IDX_W          = 3;
  localparam int IN_CNT_W       = 8;
  localparam int CHG_W          = 24;
  localparam int REFILL_W       = 16;
  localparam int OUT_W          = 16;
  localparam int DEN_W          = 14;
  localparam int MAGIC_W        = 25;
  localparam int SHIFT_W        = 6;
  localparam int PROD_W         = CHG_W + MAGIC_W;
  localparam int STOCK_BITS_DEF = 16;
  localparam int RESET_STOCK    = 10;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;
  localparam logic [1:0] ST_BAD_IDX = 2'd3;

  // denominations, highest first
  localparam logic [DEN_W-1:0] DENOM_VALUE [NUM_DENOMS] = '{
    14'd10000, 14'd5000, 14'd1000, 14'd500, 14'd100, 14'd50, 14'd10
  };

  // floor(x / d) == (x * m) >> s for any 24-bit x, m = ceil(2^s / d),
  // s = 24 + ceil(log2 d)
  localparam logic [MAGIC_W-1:0] DIV_MAGIC [NUM_DENOMS] = '{
    25'd27487791, 25'd27487791, 25'd17179870, 25'd17179870,
    25'd21474837, 25'd21474837, 25'd26843546
  };

  localparam logic [SHIFT_W-1:0] DIV_SHIFT [NUM_DENOMS] = '{
    6'd38, 6'd37, 6'd34, 6'd33, 6'd31, 6'd30, 6'd28
  };

  typedef struct packed {
    logic             work_wr;
    logic             stock_wr;
    logic             commit;
    logic [IDX_W-1:0] idx;
  } stock_cmd_t;

endpackage

// ===== sv/change_dispenser_with_coin_stock_unit.sv =====
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   in_kind, in_10000..in_10, in_change_amount,
//                                           in_refill_index, in_refill_count
// out      output     out_valid / out_ready out_status, out_locked, out_10000..out_10
//
// a payment holds the sequencer from the accept step through a divide step and
// a take step per denomination (both in the shared divide / take unit) to the
// finish step, which loads the result register; refills and refused
// payments go from the accept step straight to the finish step
// reset is synchronous, active low; stock comes up at ten per denomination
// in_ready is high only while the sequencer is idle
// a result waits in the output register; a stalled out_ready holds the
// next item in its finish step
module change_dispenser_with_coin_stock_unit #(
  parameter int STOCK_BITS = chg_pkg::STOCK_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_10000,
  input  logic [7:0]  in_5000,
  input  logic [7:0]  in_1000,
  input  logic [7:0]  in_500,
  input  logic [7:0]  in_100,
  input  logic [7:0]  in_50,
  input  logic [7:0]  in_10,
  input  logic [23:0] in_change_amount,
  input  logic [2:0]  in_refill_index,
  input  logic [15:0] in_refill_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_locked,
  output logic [15:0] out_10000,
  output logic [15:0] out_5000,
  output logic [15:0] out_1000,
  output logic [15:0] out_500,
  output logic [15:0] out_100,
  output logic [15:0] out_50,
  output logic [15:0] out_10
);

  localparam int ND    = chg_pkg::NUM_DENOMS;
  localparam int IDX_W = chg_pkg::IDX_W;
  localparam int CHG_W = chg_pkg::CHG_W;
  localparam int OUT_W = chg_pkg::OUT_W;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_TAKE = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ND - 1);

  logic [1:0]                    state_r, state_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic                          locked_r, locked_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [CHG_W-1:0]              rem_r, rem_nxt;

  // captured transaction
  logic                          kind_r;
  logic [chg_pkg::IN_CNT_W-1:0]  cnt_r [ND];
  logic [IDX_W-1:0]              rf_idx_r;
  logic [chg_pkg::REFILL_W-1:0]  rf_cnt_r;

  logic [OUT_W-1:0]              given_r [ND];
  logic [1:0]                    out_status_r;
  logic                          out_locked_r;
  logic [OUT_W-1:0]              out_cnt_r [ND];

  logic [chg_pkg::IN_CNT_W-1:0]  in_cnt [ND];
  logic                          in_accept;
  logic                          fin_go;
  logic                          rf_ok;
  logic                          pay_ok;
  logic                          div_en;
  logic [chg_pkg::REFILL_W-1:0]  addend;
  logic [STOCK_BITS-1:0]         wdata;
  chg_pkg::stock_cmd_t           stk_cmd;

  logic [STOCK_BITS-1:0]         rd_stock;
  logic [STOCK_BITS-1:0]         rd_work;
  logic [STOCK_BITS-1:0]         sat_sum;
  logic [CHG_W-1:0]              take;
  logic [CHG_W-1:0]              rem_left;
  logic [STOCK_BITS-1:0]         work_left;

  assign in_cnt[0] = in_10000;
  assign in_cnt[1] = in_5000;
  assign in_cnt[2] = in_1000;
  assign in_cnt[3] = in_500;
  assign in_cnt[4] = in_100;
  assign in_cnt[5] = in_50;
  assign in_cnt[6] = in_10;

  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign rf_ok     = (rf_idx_r < IDX_W'(ND));
  assign pay_ok    = (rem_r == '0);

  // shared divide / take / saturating add unit
  chg_alu #(
    .STOCK_BITS (STOCK_BITS)
  ) u_alu (
    .clk       (clk),
    .idx       (idx_r),
    .div_en    (div_en),
    .rem       (rem_r),
    .stock_val (rd_stock),
    .addend    (addend),
    .work_val  (rd_work),
    .sat_sum   (sat_sum),
    .take      (take),
    .rem_left  (rem_left),
    .work_left (work_left)
  );

  chg_stock #(
    .STOCK_BITS (STOCK_BITS)
  ) u_stock (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (stk_cmd),
    .wdata    (wdata),
    .rd_stock (rd_stock),
    .rd_work  (rd_work)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    locked_nxt    = locked_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_en        = 1'b0;
    stk_cmd       = '0;
    stk_cmd.idx   = idx_r;
    addend        = chg_pkg::REFILL_W'(cnt_r[idx_r]);
    wdata         = sat_sum;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          idx_nxt   = '0;
          rem_nxt   = in_change_amount;
          state_nxt = (in_kind || locked_r) ? S_FIN : S_DIV;
        end
      end
      S_DIV: begin
        // stock plus inserted units into scratch, latch quotient
        div_en          = 1'b1;
        stk_cmd.work_wr = 1'b1;
        state_nxt       = S_TAKE;
      end
      S_TAKE: begin
        stk_cmd.work_wr = 1'b1;
        wdata           = work_left;
        rem_nxt         = rem_left;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_FIN: begin
        stk_cmd.idx = (kind_r && rf_ok) ? rf_idx_r : '0;
        addend      = rf_cnt_r;
        if (fin_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (kind_r) begin
            if (rf_ok) begin
              stk_cmd.stock_wr = 1'b1;
              if (rf_cnt_r != '0) begin
                locked_nxt = 1'b0;
              end
            end
          end else if (!locked_r) begin
            if (pay_ok) begin
              stk_cmd.commit = 1'b1;
            end else begin
              locked_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      locked_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      locked_r    <= locked_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (in_accept) begin
      kind_r   <= in_kind;
      rf_idx_r <= in_refill_index;
      rf_cnt_r <= in_refill_count;
      for (int i = 0; i < ND; i++) begin
        cnt_r[i] <= in_cnt[i];
      end
    end
    if (state_r == S_TAKE) begin
      given_r[idx_r] <= take[OUT_W-1:0];
    end
    if (fin_go) begin
      out_locked_r <= locked_nxt;
      if (kind_r) begin
        out_status_r <= rf_ok ? chg_pkg::ST_OK : chg_pkg::ST_BAD_IDX;
      end else if (locked_r) begin
        out_status_r <= chg_pkg::ST_REFUSED;
      end else if (pay_ok) begin
        out_status_r <= chg_pkg::ST_OK;
      end else begin
        out_status_r <= chg_pkg::ST_SHORT;
      end
      for (int i = 0; i < ND; i++) begin
        out_cnt_r[i] <= (!kind_r && !locked_r && pay_ok) ? given_r[i] : '0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_locked = out_locked_r;
  assign out_10000  = out_cnt_r[0];
  assign out_5000   = out_cnt_r[1];
  assign out_1000   = out_cnt_r[2];
  assign out_500    = out_cnt_r[3];
  assign out_100    = out_cnt_r[4];
  assign out_50     = out_cnt_r[5];
  assign out_10     = out_cnt_r[6];

  // stock is committed only when the change was paid in full
  assert property (@(posedge clk) disable iff (!rst_n)
    stk_cmd.commit |-> (rem_r == '0))
    else $error("stock commit with change left over");

  // a short change result always reports the block locked
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == chg_pkg::ST_SHORT) |-> out_locked_r)
    else $error("short change without lock");

  // the remaining change never grows during the greedy pass
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAKE) |=> (rem_r <= $past(rem_r)))
    else $error("remaining change grew");

endmodule

// ===== sv/chg_alu.sv =====
module chg_alu #(
  parameter int STOCK_BITS = chg_pkg::STOCK_BITS_DEF
) (
  input  logic                         clk,
  input  logic [chg_pkg::IDX_W-1:0]    idx,
  input  logic                         div_en,
  input  logic [chg_pkg::CHG_W-1:0]    rem,
  input  logic [STOCK_BITS-1:0]        stock_val,
  input  logic [chg_pkg::REFILL_W-1:0] addend,
  input  logic [STOCK_BITS-1:0]        work_val,
  output logic [STOCK_BITS-1:0]        sat_sum,
  output logic [chg_pkg::CHG_W-1:0]    take,
  output logic [chg_pkg::CHG_W-1:0]    rem_left,
  output logic [STOCK_BITS-1:0]        work_left
);

  localparam int CHG_W = chg_pkg::CHG_W;
  localparam int CMP_W = (STOCK_BITS > CHG_W) ? STOCK_BITS : CHG_W;
  localparam int SUM_W =
    ((STOCK_BITS > chg_pkg::REFILL_W) ? STOCK_BITS : chg_pkg::REFILL_W) + 1;
  localparam int SUB_W = CHG_W + chg_pkg::DEN_W;

  logic [SUM_W-1:0]          sum;
  logic [SUM_W-1:0]          stock_max;
  logic [chg_pkg::PROD_W-1:0] prod;
  logic [chg_pkg::PROD_W-1:0] prod_sh;
  logic [CHG_W-1:0]          q_r;
  logic [CHG_W-1:0]          q_nxt;
  logic [CMP_W-1:0]          q_ext;
  logic [CMP_W-1:0]          w_ext;
  logic [CMP_W-1:0]          take_ext;
  logic [SUB_W-1:0]          sub_prod;

  // saturating add
  assign stock_max = {{(SUM_W-STOCK_BITS){1'b0}}, {STOCK_BITS{1'b1}}};
  assign sum       = SUM_W'(stock_val) + SUM_W'(addend);
  assign sat_sum   = (sum > stock_max) ? {STOCK_BITS{1'b1}} : sum[STOCK_BITS-1:0];

  // quotient by reciprocal multiply
  assign prod    = chg_pkg::PROD_W'(rem) * chg_pkg::PROD_W'(chg_pkg::DIV_MAGIC[idx]);
  assign prod_sh = prod >> chg_pkg::DIV_SHIFT[idx];
  assign q_nxt   = prod_sh[CHG_W-1:0];

  always_ff @(posedge clk) begin
    if (div_en) begin
      q_r <= q_nxt;
    end
  end

  // take as many as wanted, limited by stock
  assign q_ext     = CMP_W'(q_r);
  assign w_ext     = CMP_W'(work_val);
  assign take_ext  = (q_ext < w_ext) ? q_ext : w_ext;
  assign take      = take_ext[CHG_W-1:0];
  assign work_left = STOCK_BITS'(w_ext - take_ext);
  assign sub_prod  = SUB_W'(take) * SUB_W'(chg_pkg::DENOM_VALUE[idx]);
  assign rem_left  = rem - sub_prod[CHG_W-1:0];

endmodule

// ===== sv/chg_stock.sv =====
module chg_stock #(
  parameter int STOCK_BITS = chg_pkg::STOCK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  chg_pkg::stock_cmd_t   cmd,
  input  logic [STOCK_BITS-1:0] wdata,
  output logic [STOCK_BITS-1:0] rd_stock,
  output logic [STOCK_BITS-1:0] rd_work
);

  logic [STOCK_BITS-1:0] stock_r [chg_pkg::NUM_DENOMS];
  logic [STOCK_BITS-1:0] work_r  [chg_pkg::NUM_DENOMS];

  assign rd_stock = stock_r[cmd.idx];
  assign rd_work  = work_r[cmd.idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < chg_pkg::NUM_DENOMS; i++) begin
        stock_r[i] <= STOCK_BITS'(chg_pkg::RESET_STOCK);
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < chg_pkg::NUM_DENOMS; i++) begin
        stock_r[i] <= work_r[i];
      end
    end else if (cmd.stock_wr) begin
      stock_r[cmd.idx] <= wdata;
    end
  end

  // scratch copy for the greedy pass, dropped if the change falls short
  always_ff @(posedge clk) begin
    if (cmd.work_wr) begin
      work_r[cmd.idx] <= wdata;
    end
  end

endmodule
